// ===== hw/rtl/atilt_pkg.sv =====
// ----------------------------------------------------------------------------
// atilt_pkg
// Shared constants for the accelerometer tilt angle pipeline: widths, CORDIC
// arctangent table, gain compensation and output limits.
// ----------------------------------------------------------------------------
package atilt_pkg;

	localparam int SAMPLE_WIDTH_DEF  = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// samples are scaled up by this many bits before the CORDIC datapath
	localparam int GUARD_BITS = 12;

	// 1/K in Q0.16 and the shift that drops the fraction bits of its product
	localparam logic [15:0] INV_GAIN   = 16'd39797;
	localparam int          GAIN_SHIFT = 16;

	// angle accumulator in Q30, output in Q2.13
	localparam int ZW          = 33;
	localparam int Q13_SHIFT   = 17;
	localparam int RW          = ZW - Q13_SHIFT;
	localparam int OUT_W       = 15;

	localparam logic signed [ZW-1:0] ROUND_Q13   = 33'sd65536;
	localparam logic signed [RW-1:0] ANGLE_LIMIT = 16'sd12868;

	localparam int ANGLE_TABLE_LEN = 24;

	// atan(2^-i) * 2^30, truncated
	localparam logic signed [ZW-1:0] ATAN_Q30 [ANGLE_TABLE_LEN] = '{
		33'sh03243F6A8, 33'sh01DAC6705, 33'sh00FADBAFC, 33'sh007F56EA6,
		33'sh003FEAB76, 33'sh001FFD55B, 33'sh000FFFAAA, 33'sh0007FFF55,
		33'sh0003FFFEA, 33'sh0001FFFFD, 33'sh0000FFFFF, 33'sh00007FFFF,
		33'sh00003FFFF, 33'sh00001FFFF, 33'sh00000FFFF, 33'sh000007FFF,
		33'sh000003FFF, 33'sh000001FFF, 33'sh000000FFF, 33'sh0000007FF,
		33'sh0000003FF, 33'sh0000001FF, 33'sh0000000FF, 33'sh00000007F
	};

endpackage

// ===== hw/rtl/accel_tilt_angles.sv =====
// result: a sample taken with start passes through every stage below, and its result is on the
// outputs while done is high (done high for a single cycle)
// throughput: one sample per clock, set by the fully unrolled CORDIC stages; busy stays low
// pipeline: input stage, N magnitude stages (N is CORDIC_STAGES capped at ANGLE_TABLE_LEN),
// gain multiply stage, N angle stages, round/saturate output stage
// reset clears the valid bits of every stage; data registers are not reset
// ----------------------------------------------------------------------------
// accel_tilt_angles
// Pitch and roll style tilt angles from one three-axis accelerometer sample,
// using CORDIC vectoring for the magnitude and again for the arctangent.
// ----------------------------------------------------------------------------
module accel_tilt_angles
	import atilt_pkg::*;
#(
	parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
	output logic                           done,
	output logic signed [OUT_W-1:0]        tilt_about_x,
	output logic signed [OUT_W-1:0]        tilt_about_y
);

	localparam int DW  = SAMPLE_WIDTH + GUARD_BITS + 3;
	localparam int N   = (CORDIC_STAGES > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN : CORDIC_STAGES;
	localparam int PW  = DW + GAIN_SHIFT;
	localparam int LAT = 2 * N + 3;

	function automatic logic signed [DW-1:0] scale(input logic signed [SAMPLE_WIDTH-1:0] s);
		return {{3{s[SAMPLE_WIDTH-1]}}, s, {GUARD_BITS{1'b0}}};
	endfunction

	function automatic logic signed [DW-1:0] absv(input logic signed [DW-1:0] v);
		return v[DW-1] ? -v : v;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_angle(input logic signed [ZW-1:0] z,
			input logic zero);
		logic signed [ZW-1:0] zs;
		logic signed [RW-1:0] zr;
		zs = z + ROUND_Q13;
		zr = zs[ZW-1:Q13_SHIFT];
		if (zero) begin
			zr = '0;
		end else if (zr > ANGLE_LIMIT) begin
			zr = ANGLE_LIMIT;
		end else if (zr < -ANGLE_LIMIT) begin
			zr = -ANGLE_LIMIT;
		end
		return zr[OUT_W-1:0];
	endfunction

	logic take;
	logic signed [DW-1:0] sx, sy, sz;

	// magnitude lanes: a = |(y, z)|, b = |(x, z)|; numerators ride along
	logic signed [DW-1:0] ma_x_s [N+1];
	logic signed [DW-1:0] ma_y_s [N+1];
	logic signed [DW-1:0] mb_x_s [N+1];
	logic signed [DW-1:0] mb_y_s [N+1];
	logic signed [DW-1:0] nx_s   [N+1];
	logic signed [DW-1:0] ny_s   [N+1];
	logic [N:0]           mv_s;

	// angle lanes
	logic signed [DW-1:0] aa_x_s [N+1];
	logic signed [DW-1:0] aa_y_s [N+1];
	logic signed [ZW-1:0] aa_z_s [N+1];
	logic signed [DW-1:0] ab_x_s [N+1];
	logic signed [DW-1:0] ab_y_s [N+1];
	logic signed [ZW-1:0] ab_z_s [N+1];
	logic [N:0]           zfa_s;
	logic [N:0]           zfb_s;
	logic [N:0]           av_s;

	logic [PW-1:0]        prod_a, prod_b;
	logic signed [DW-1:0] den_a, den_b;

	logic                    done_q;
	logic signed [OUT_W-1:0] tilt_x_q, tilt_y_q;

	assign busy = 1'b0;
	assign take = start & ~busy;
	assign sx   = scale(accel_x);
	assign sy   = scale(accel_y);
	assign sz   = scale(accel_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s   <= '0;
			av_s   <= '0;
			done_q <= 1'b0;
		end else begin
			mv_s   <= {mv_s[N-1:0], take};
			av_s   <= {av_s[N-1:0], mv_s[N]};
			done_q <= av_s[N];
		end
	end

	always_ff @(posedge clk) begin
		ma_x_s[0] <= absv(sz);
		ma_y_s[0] <= absv(sy);
		mb_x_s[0] <= absv(sz);
		mb_y_s[0] <= absv(sx);
		nx_s[0]   <= sx;
		ny_s[0]   <= sy;
	end

	for (genvar k = 0; k < N; k++) begin : g_mag
		always_ff @(posedge clk) begin
			if (!ma_y_s[k][DW-1]) begin
				ma_x_s[k+1] <= ma_x_s[k] + (ma_y_s[k] >>> k);
				ma_y_s[k+1] <= ma_y_s[k] - (ma_x_s[k] >>> k);
			end else begin
				ma_x_s[k+1] <= ma_x_s[k] - (ma_y_s[k] >>> k);
				ma_y_s[k+1] <= ma_y_s[k] + (ma_x_s[k] >>> k);
			end
			if (!mb_y_s[k][DW-1]) begin
				mb_x_s[k+1] <= mb_x_s[k] + (mb_y_s[k] >>> k);
				mb_y_s[k+1] <= mb_y_s[k] - (mb_x_s[k] >>> k);
			end else begin
				mb_x_s[k+1] <= mb_x_s[k] - (mb_y_s[k] >>> k);
				mb_y_s[k+1] <= mb_y_s[k] + (mb_x_s[k] >>> k);
			end
			nx_s[k+1] <= nx_s[k];
			ny_s[k+1] <= ny_s[k];
		end
	end

	// gain compensation, rounded half up
	always_comb begin
		prod_a = PW'(ma_x_s[N]) * PW'(INV_GAIN) + PW'(1 << (GAIN_SHIFT - 1));
		prod_b = PW'(mb_x_s[N]) * PW'(INV_GAIN) + PW'(1 << (GAIN_SHIFT - 1));
		den_a  = (ma_x_s[N] <= 0) ? '0 : prod_a[PW-1:GAIN_SHIFT];
		den_b  = (mb_x_s[N] <= 0) ? '0 : prod_b[PW-1:GAIN_SHIFT];
	end

	// a compensated magnitude is zero exactly when the raw one is not positive
	always_ff @(posedge clk) begin
		aa_x_s[0] <= den_a;
		aa_y_s[0] <= nx_s[N];
		aa_z_s[0] <= '0;
		zfa_s[0]  <= (nx_s[N] == 0) && (ma_x_s[N] <= 0);
		ab_x_s[0] <= den_b;
		ab_y_s[0] <= ny_s[N];
		ab_z_s[0] <= '0;
		zfb_s[0]  <= (ny_s[N] == 0) && (mb_x_s[N] <= 0);
	end

	for (genvar k = 0; k < N; k++) begin : g_ang
		always_ff @(posedge clk) begin
			if (!aa_y_s[k][DW-1]) begin
				aa_x_s[k+1] <= aa_x_s[k] + (aa_y_s[k] >>> k);
				aa_y_s[k+1] <= aa_y_s[k] - (aa_x_s[k] >>> k);
				aa_z_s[k+1] <= aa_z_s[k] + ATAN_Q30[k];
			end else begin
				aa_x_s[k+1] <= aa_x_s[k] - (aa_y_s[k] >>> k);
				aa_y_s[k+1] <= aa_y_s[k] + (aa_x_s[k] >>> k);
				aa_z_s[k+1] <= aa_z_s[k] - ATAN_Q30[k];
			end
			if (!ab_y_s[k][DW-1]) begin
				ab_x_s[k+1] <= ab_x_s[k] + (ab_y_s[k] >>> k);
				ab_y_s[k+1] <= ab_y_s[k] - (ab_x_s[k] >>> k);
				ab_z_s[k+1] <= ab_z_s[k] + ATAN_Q30[k];
			end else begin
				ab_x_s[k+1] <= ab_x_s[k] - (ab_y_s[k] >>> k);
				ab_y_s[k+1] <= ab_y_s[k] + (ab_x_s[k] >>> k);
				ab_z_s[k+1] <= ab_z_s[k] - ATAN_Q30[k];
			end
			zfa_s[k+1] <= zfa_s[k];
			zfb_s[k+1] <= zfb_s[k];
		end
	end

	always_ff @(posedge clk) begin
		tilt_x_q <= sat_angle(aa_z_s[N], zfa_s[N]);
		tilt_y_q <= sat_angle(ab_z_s[N], zfb_s[N]);
	end

	assign done         = done_q;
	assign tilt_about_x = tilt_x_q;
	assign tilt_about_y = tilt_y_q;

`ifndef SYNTHESIS
	// every result strobe traces back to a transfer a fixed latency earlier
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching input transfer");

	// an all-zero sample gives zero for both angles
	a_zero_sample: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy && accel_x == 0 && accel_y == 0 && accel_z == 0, LAT)
		|-> tilt_about_x == 0 && tilt_about_y == 0)
		else $error("all-zero sample gave a nonzero angle");

	// saturation keeps both angles within plus or minus pi/2
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> tilt_about_x <= ANGLE_LIMIT && tilt_about_x >= -ANGLE_LIMIT
			&& tilt_about_y <= ANGLE_LIMIT && tilt_about_y >= -ANGLE_LIMIT)
		else $error("tilt angle outside the saturation limit");
`endif

endmodule
